// ===== hdl/jvds_pkg.sv =====
// ----------------------------------------------------------------------------
// jvds_pkg
// Shared types, character codes and helpers for the JSON value scanner.
// ----------------------------------------------------------------------------
package jvds_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_IN    = 2'd0,
    ST_COMMA = 2'd1,
    ST_CLOSE = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Quote tracking codes
  localparam logic [1:0] QM_NORMAL = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Number of hex digits collected after \u
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // Scanner state outside the bracket stack.
  // The hex accumulator keeps only the low byte of the collected code.
  typedef struct packed {
    logic       value_started;
    logic       escape_pending;
    logic [1:0] quote_mode;
    logic [2:0] hex_left;
    logic [7:0] hex_accum;
    logic       hex_still_valid;
  } scan_state_t;

  // Stack control from the step logic
  typedef struct packed {
    logic push;
    logic push_obj;
    logic pop;
    logic clear;
  } stack_op_t;

  // Stack status back to the step logic
  typedef struct packed {
    logic empty;
    logic full;
    logic top_obj;
  } stack_info_t;

  // Hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== hdl/jvds_nest_stack.sv =====
// ----------------------------------------------------------------------------
// jvds_nest_stack
// Bracket stack as a shift line: the top entry always sits in slot 0.
// ----------------------------------------------------------------------------
module jvds_nest_stack #(
  parameter int NEST_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  jvds_pkg::stack_op_t   op,
  output jvds_pkg::stack_info_t info
);

  localparam int CW = $clog2(NEST_DEPTH + 1);

  logic [NEST_DEPTH-1:0] slots;
  logic [CW-1:0]         count;

  // Fill level, cleared at the end of every value
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      if (op.clear) begin
        count <= '0;
      end else if (op.push) begin
        count <= count + CW'(1);
      end else if (op.pop) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entries shift down on push, up on pop; contents need no reset
  for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_slot
    logic below;
    logic above;
    if (i == 0) begin : g_first
      assign below = op.push_obj;
    end else begin : g_rest
      assign below = slots[i-1];
    end
    if (i == NEST_DEPTH - 1) begin : g_last
      assign above = slots[i];
    end else begin : g_mid
      assign above = slots[i+1];
    end
    always_ff @(posedge clk) begin
      if (step && !op.clear) begin
        if (op.push) begin
          slots[i] <= below;
        end else if (op.pop) begin
          slots[i] <= above;
        end
      end
    end
  end

  assign info.empty   = (count == '0);
  assign info.full    = (count == CW'(NEST_DEPTH));
  assign info.top_obj = slots[0];

endmodule

// ===== hdl/jvds_step.sv =====
// ----------------------------------------------------------------------------
// jvds_step
// Per-byte decision logic: next scan state, stack action and result beat.
// ----------------------------------------------------------------------------
module jvds_step (
  input  jvds_pkg::scan_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_input,
  input  logic                  array_format,
  input  jvds_pkg::stack_info_t stk,
  output jvds_pkg::scan_state_t nxt,
  output jvds_pkg::stack_op_t   op,
  output logic [7:0]            res_byte,
  output logic                  res_bit,
  output jvds_pkg::status_t     res_status
);

  logic [4:0] hd;
  logic [7:0] acc_next;
  logic       want_obj;

  assign hd       = jvds_pkg::hex_digit(data_byte);
  assign want_obj = (data_byte == jvds_pkg::CH_RBRACE);

  always_comb begin
    nxt        = cur;
    op         = '0;
    res_byte   = data_byte;
    res_bit    = 1'b0;
    res_status = jvds_pkg::ST_IN;
    acc_next   = cur.hex_accum;

    if (end_of_input) begin
      res_status = jvds_pkg::ST_BAD;
    end else if (cur.hex_left != 3'd0) begin
      // \u digit collection; a non-hex byte stops accumulation
      if (cur.hex_still_valid && hd[4]) begin
        acc_next = {cur.hex_accum[3:0], hd[3:0]};
      end else begin
        nxt.hex_still_valid = 1'b0;
      end
      nxt.hex_accum = acc_next;
      nxt.hex_left  = cur.hex_left - 3'd1;
      if (cur.hex_left == 3'd1) begin
        res_byte            = acc_next;
        res_bit             = 1'b1;
        nxt.hex_accum       = '0;
        nxt.hex_still_valid = 1'b0;
      end
    end else if (data_byte == jvds_pkg::CH_NUL) begin
      res_status = jvds_pkg::ST_BAD;
    end else if (!cur.value_started && data_byte inside {jvds_pkg::CH_SPACE,
                 jvds_pkg::CH_TAB, jvds_pkg::CH_LF, jvds_pkg::CH_CR}) begin
      // leading whitespace skipped
      res_bit = 1'b0;
    end else begin
      nxt.value_started = 1'b1;
      res_bit           = 1'b1;
      if (cur.escape_pending) begin
        nxt.escape_pending = 1'b0;
        case (data_byte)
          jvds_pkg::CH_N: res_byte = jvds_pkg::CH_LF;
          jvds_pkg::CH_R: res_byte = jvds_pkg::CH_CR;
          jvds_pkg::CH_T: res_byte = jvds_pkg::CH_TAB;
          jvds_pkg::CH_U: begin
            res_bit             = 1'b0;
            nxt.hex_left        = jvds_pkg::HEX_DIGITS;
            nxt.hex_accum       = '0;
            nxt.hex_still_valid = 1'b1;
          end
          default: res_byte = data_byte;
        endcase
      end else if (data_byte == jvds_pkg::CH_BSLASH) begin
        nxt.escape_pending = 1'b1;
      end else if (cur.quote_mode == jvds_pkg::QM_SINGLE) begin
        if (data_byte == jvds_pkg::CH_SQUOTE) nxt.quote_mode = jvds_pkg::QM_NORMAL;
      end else if (cur.quote_mode == jvds_pkg::QM_DOUBLE) begin
        if (data_byte == jvds_pkg::CH_DQUOTE) nxt.quote_mode = jvds_pkg::QM_NORMAL;
      end else if (data_byte == jvds_pkg::CH_LBRACK ||
                   data_byte == jvds_pkg::CH_LBRACE) begin
        // open bracket: push, or overflow
        if (stk.full) begin
          res_bit    = 1'b0;
          res_status = jvds_pkg::ST_BAD;
        end else begin
          op.push     = 1'b1;
          op.push_obj = (data_byte == jvds_pkg::CH_LBRACE);
        end
      end else if (data_byte == jvds_pkg::CH_SQUOTE) begin
        nxt.quote_mode = jvds_pkg::QM_SINGLE;
      end else if (data_byte == jvds_pkg::CH_DQUOTE) begin
        nxt.quote_mode = jvds_pkg::QM_DOUBLE;
      end else if (!stk.empty) begin
        // nested close must match the open bracket
        if (data_byte == jvds_pkg::CH_RBRACK || data_byte == jvds_pkg::CH_RBRACE) begin
          if (stk.top_obj != want_obj) begin
            res_bit    = 1'b0;
            res_status = jvds_pkg::ST_BAD;
          end else begin
            op.pop = 1'b1;
          end
        end
      end else begin
        // top level delimiters end the value
        case (data_byte)
          jvds_pkg::CH_COMMA: begin
            res_bit    = 1'b0;
            res_status = jvds_pkg::ST_COMMA;
          end
          jvds_pkg::CH_RBRACK: begin
            res_bit    = 1'b0;
            res_status = jvds_pkg::ST_CLOSE;
          end
          jvds_pkg::CH_RBRACE: begin
            res_bit    = 1'b0;
            res_status = array_format ? jvds_pkg::ST_BAD : jvds_pkg::ST_CLOSE;
          end
          default: res_bit = 1'b1;
        endcase
      end
    end

    // any end of value resets scanning
    if (res_status != jvds_pkg::ST_IN) begin
      nxt      = '0;
      op       = '0;
      op.clear = 1'b1;
    end
    if (!res_bit) res_byte = '0;
  end

endmodule

// ===== hdl/json_value_delimiter_scanner_core.sv =====
// ----------------------------------------------------------------------------
// json_value_delimiter_scanner_core
// A beat passes the input register, then the combinational step logic and the
//   result register; throughput one byte per cycle while the result side is ready.
// Reset (rst, synchronous): clears scan state, stack fill level, both
//   pipeline valid flags and array_format; no clearing pass.
// Scans a JSON-like byte stream and marks where one value ends.
// ----------------------------------------------------------------------------
module json_value_delimiter_scanner_core #(
  parameter int NEST_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  // input beats
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  // result beats
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic [1:0] status
);

  logic                  array_format;
  logic                  in_full;
  logic [7:0]            byte_q;
  logic                  eoi_q;
  logic                  advance;
  jvds_pkg::scan_state_t scan;
  jvds_pkg::scan_state_t scan_next;
  jvds_pkg::stack_op_t   op;
  jvds_pkg::stack_info_t stk;
  logic [7:0]            res_byte;
  logic                  res_bit;
  jvds_pkg::status_t     res_status;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      array_format <= 1'b0;
    end else if (cfg_valid) begin
      array_format <= cfg_data;
    end
  end

  // Handshake: a byte moves on whenever the result register is free
  assign advance  = in_full && (!res_valid || res_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
      eoi_q  <= end_of_input;
    end
  end

  // Step logic
  jvds_step u_step (
    .cur          (scan),
    .data_byte    (byte_q),
    .end_of_input (eoi_q),
    .array_format (array_format),
    .stk          (stk),
    .nxt          (scan_next),
    .op           (op),
    .res_byte     (res_byte),
    .res_bit      (res_bit),
    .res_status   (res_status)
  );

  // Bracket stack
  jvds_nest_stack #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .op   (op),
    .info (stk)
  );

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= res_byte;
      out_valid <= res_bit;
      status    <= res_status;
    end
  end

`ifndef SYNTHESIS
  // a ready sink never stalls the source
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> in_ready)
    else $error("input stalled while result side ready");

  // a beat without data carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_byte == 8'd0))
    else $error("nonzero byte on empty result beat");

  // ending beats never carry a byte
  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != jvds_pkg::ST_IN) |-> !out_valid)
    else $error("ending beat carries a byte");

  // end of value clears scanning state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res_status != jvds_pkg::ST_IN) |=>
      (!scan.value_started && scan.hex_left == 3'd0 && stk.empty))
    else $error("scan state not cleared after end of value");

  // no escape is pending while hex digits are collected
  a_hex_no_escape: assert property (@(posedge clk) disable iff (rst)
    (scan.hex_left != 3'd0) |-> !scan.escape_pending)
    else $error("escape pending during hex collection");
`endif

endmodule

// ===== test/json_value_delimiter_scanner_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_value_delimiter_scanner_core_tb
// Self-checking bench for the JSON value scanner. A short directed table of
// text bytes comes first, then random values, deep nesting and noise, over
// both array_format settings. Every result beat is checked against a
// scoreboard fed by a behavioral scanner model or the table rows, with random
// stalls on both sides, one long output hold-off and a quiet final stretch.
// ----------------------------------------------------------------------------
module json_value_delimiter_scanner_core_tb;

  localparam int NEST_DEPTH = 32;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BEATS = 55;

  // One result beat
  typedef struct packed {
    logic [7:0]          ob;
    logic                ov;
    jvds_pkg::status_t   st;
  } scan_res_t;

  // One row of the directed table
  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         typed;
    scan_res_t  want;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] status;

  // Scanner model state
  logic        fmt_array;
  logic        started;
  logic        esc_pend;
  logic [1:0]  qmode;
  logic        nest_is_obj [NEST_DEPTH];
  logic [5:0]  nest_lvl;
  logic [2:0]  hex_left;
  logic [15:0] hex_acc;
  logic        hex_ok;

  scan_res_t expected_q[$];
  dir_row_t  dir_rows[$];
  scan_res_t head;
  int        mismatches = 0;
  int        results_seen = 0;
  int        beats_sent = 0;
  int        quiet = 0;
  bit        gaps_on = 1'b1;
  bit        hold_req = 1'b0;

  json_value_delimiter_scanner_core #(
    .NEST_DEPTH(NEST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .end_of_input(end_of_input),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_byte(out_byte),
    .out_valid(out_valid),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_scan_state();
    started  = 1'b0;
    esc_pend = 1'b0;
    qmode    = jvds_pkg::QM_NORMAL;
    nest_lvl = '0;
    hex_left = '0;
    hex_acc  = '0;
    hex_ok   = 1'b0;
  endfunction

  // Advance the scanner model by one text byte and give its result
  function automatic void scan_byte(input logic [7:0] c, input logic eoi,
                                    output scan_res_t r);
    logic [7:0] tmp;
    logic [3:0] dig;
    logic       is_hex;
    r.ob = 8'h00;
    r.ov = 1'b0;
    r.st = jvds_pkg::ST_IN;
    if (eoi) begin
      r.st = jvds_pkg::ST_BAD;
    end else if (hex_left != 0) begin
      // collecting the four bytes after \u
      is_hex = 1'b1;
      tmp = 8'h00;
      if (c >= "0" && c <= "9") tmp = c - 8'h30;
      else if (c >= "a" && c <= "f") tmp = c - 8'h57;
      else if (c >= "A" && c <= "F") tmp = c - 8'h37;
      else is_hex = 1'b0;
      dig = tmp[3:0];
      if (hex_ok && is_hex) hex_acc = {hex_acc[11:0], dig};
      else hex_ok = 1'b0;
      hex_left = hex_left - 3'd1;
      if (hex_left == 0) begin
        r.ob = hex_acc[7:0];
        r.ov = 1'b1;
        hex_acc = '0;
        hex_ok = 1'b0;
      end
    end else if (c == jvds_pkg::CH_NUL) begin
      r.st = jvds_pkg::ST_BAD;
    end else if (!started &&
                 (c == jvds_pkg::CH_SPACE || c == jvds_pkg::CH_TAB ||
                  c == jvds_pkg::CH_LF || c == jvds_pkg::CH_CR)) begin
      // leading whitespace, skipped
    end else begin
      started = 1'b1;
      r.ob = c;
      r.ov = 1'b1;
      if (esc_pend) begin
        esc_pend = 1'b0;
        case (c)
          jvds_pkg::CH_N: r.ob = jvds_pkg::CH_LF;
          jvds_pkg::CH_R: r.ob = jvds_pkg::CH_CR;
          jvds_pkg::CH_T: r.ob = jvds_pkg::CH_TAB;
          jvds_pkg::CH_U: begin
            hex_left = jvds_pkg::HEX_DIGITS;
            hex_acc  = '0;
            hex_ok   = 1'b1;
            r.ob = 8'h00;
            r.ov = 1'b0;
          end
          default: ;
        endcase
      end else if (c == jvds_pkg::CH_BSLASH) begin
        esc_pend = 1'b1;
      end else if (qmode == jvds_pkg::QM_SINGLE) begin
        if (c == jvds_pkg::CH_SQUOTE) qmode = jvds_pkg::QM_NORMAL;
      end else if (qmode == jvds_pkg::QM_DOUBLE) begin
        if (c == jvds_pkg::CH_DQUOTE) qmode = jvds_pkg::QM_NORMAL;
      end else if (c == jvds_pkg::CH_LBRACK || c == jvds_pkg::CH_LBRACE) begin
        if (nest_lvl >= NEST_DEPTH) begin
          r.st = jvds_pkg::ST_BAD;
        end else begin
          nest_is_obj[nest_lvl] = (c == jvds_pkg::CH_LBRACE);
          nest_lvl = nest_lvl + 6'd1;
        end
      end else if (c == jvds_pkg::CH_SQUOTE) begin
        qmode = jvds_pkg::QM_SINGLE;
      end else if (c == jvds_pkg::CH_DQUOTE) begin
        qmode = jvds_pkg::QM_DOUBLE;
      end else if (nest_lvl != 0) begin
        if (c == jvds_pkg::CH_RBRACK || c == jvds_pkg::CH_RBRACE) begin
          if (nest_is_obj[nest_lvl - 6'd1] != (c == jvds_pkg::CH_RBRACE))
            r.st = jvds_pkg::ST_BAD;
          else nest_lvl = nest_lvl - 6'd1;
        end
      end else if (c == jvds_pkg::CH_COMMA) begin
        r.st = jvds_pkg::ST_COMMA;
      end else if (c == jvds_pkg::CH_RBRACK) begin
        r.st = jvds_pkg::ST_CLOSE;
      end else if (c == jvds_pkg::CH_RBRACE) begin
        r.st = fmt_array ? jvds_pkg::ST_BAD : jvds_pkg::ST_CLOSE;
      end
    end
    // a finished value clears the scan and carries no byte
    if (r.st != jvds_pkg::ST_IN) begin
      r.ob = 8'h00;
      r.ov = 1'b0;
      clear_scan_state();
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eoi,
                                  input bit typed, input logic [7:0] ob,
                                  input logic ov, input jvds_pkg::status_t st);
    dir_row_t row;
    row.b = b;
    row.eoi = eoi;
    row.typed = typed;
    row.want.ob = ob;
    row.want.ov = ov;
    row.want.st = st;
    dir_rows = {dir_rows, row};
  endfunction

  // Offer one input beat and log its expected result once accepted
  task automatic send_beat(input logic [7:0] b, input logic eoi, input bit typed,
                           input scan_res_t want);
    scan_res_t got;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    scan_byte(b, eoi, got);
    expected_q = {expected_q, typed ? want : got};
    beats_sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_beat(b, 1'b0, 1'b0, '0);
  endtask

  // Stop offering beats and wait until every result is back
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_format(input logic v);
    drain(4);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fmt_array = v;
  endtask

  // One random value: nesting, strings with escapes, plain bytes, terminator
  task automatic send_value();
    logic [7:0] q[$];
    bit         kinds[$];
    logic [7:0] qch;
    logic [7:0] c;
    string      hex_chars;
    int         n;
    hex_chars = "0123456789abcdefABCDEF";
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: q = {q, jvds_pkg::CH_SPACE};
        1: q = {q, jvds_pkg::CH_TAB};
        2: q = {q, jvds_pkg::CH_LF};
        default: q = {q, jvds_pkg::CH_CR};
      endcase
    end
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          kinds = {kinds, 1'($urandom_range(0, 1))};
          q = {q, kinds[$] ? jvds_pkg::CH_LBRACE : jvds_pkg::CH_LBRACK};
        end
        1: begin
          if (kinds.size() != 0) begin
            q = {q, kinds[$] ? jvds_pkg::CH_RBRACE : jvds_pkg::CH_RBRACK};
            kinds.delete(kinds.size() - 1);
          end
        end
        2, 3: begin
          qch = $urandom_range(0, 1) ? jvds_pkg::CH_DQUOTE : jvds_pkg::CH_SQUOTE;
          q = {q, qch};
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 2) == 0) begin
              q = {q, jvds_pkg::CH_BSLASH};
              case ($urandom_range(0, 4))
                0: q = {q, jvds_pkg::CH_N};
                1: q = {q, jvds_pkg::CH_R};
                2: q = {q, jvds_pkg::CH_T};
                3: begin
                  q = {q, jvds_pkg::CH_U};
                  repeat (4) begin
                    if ($urandom_range(0, 3) == 0) q = {q, 8'($urandom_range(0, 255))};
                    else q = {q, 8'(hex_chars[$urandom_range(0, 21)])};
                  end
                end
                default: q = {q, 8'($urandom_range(1, 255))};
              endcase
            end else begin
              c = $urandom_range(0, 4) == 0 ? 8'($urandom_range(8'h80, 8'hFF))
                                            : 8'($urandom_range(8'h20, 8'h7E));
              if (c == qch || c == jvds_pkg::CH_BSLASH) c = "x";
              q = {q, c};
            end
          end
          q = {q, qch};
        end
        4: q = {q, jvds_pkg::CH_COMMA};
        default: q = {q, $urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h39))
                                              : 8'($urandom_range(8'h61, 8'h7A))};
      endcase
    end
    while (kinds.size() != 0) begin
      q = {q, kinds[$] ? jvds_pkg::CH_RBRACE : jvds_pkg::CH_RBRACK};
      kinds.delete(kinds.size() - 1);
    end
    foreach (q[i]) send_text(q[i]);
    case ($urandom_range(0, 3))
      0: send_text(jvds_pkg::CH_COMMA);
      1: send_text(jvds_pkg::CH_RBRACK);
      2: send_text(jvds_pkg::CH_RBRACE);
      default: send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    endcase
  endtask

  // Deep nesting that may run past the stack
  task automatic send_deep();
    repeat ($urandom_range(NEST_DEPTH - 2, NEST_DEPTH + 2))
      send_text($urandom_range(0, 1) ? jvds_pkg::CH_LBRACE : jvds_pkg::CH_LBRACK);
    send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // Noise with a bias toward bytes that mean something
  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) == 0) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 11))
          0: c = jvds_pkg::CH_NUL;
          1: c = jvds_pkg::CH_COMMA;
          2: c = jvds_pkg::CH_LBRACK;
          3: c = jvds_pkg::CH_RBRACK;
          4: c = jvds_pkg::CH_LBRACE;
          5: c = jvds_pkg::CH_RBRACE;
          6: c = jvds_pkg::CH_DQUOTE;
          7: c = jvds_pkg::CH_SQUOTE;
          8: c = jvds_pkg::CH_BSLASH;
          9: c = jvds_pkg::CH_U;
          10: c = jvds_pkg::CH_SPACE;
          default: c = 8'hFF;
        endcase
      end
      send_beat(c, $urandom_range(0, 7) == 0, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Scoreboard check on every result beat
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: byte %h valid %b status %0d",
                   out_byte, out_valid, status);
      end else begin
        head = expected_q.pop_front();
        if (out_byte !== head.ob || out_valid !== head.ov || status !== head.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected byte %h valid %b status %s, %s",
                     results_seen, head.ob, head.ov, head.st.name(),
                     $sformatf("got byte %h valid %b status %0d",
                               out_byte, out_valid, status));
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    fmt_array = 1'b0;
    foreach (nest_is_obj[i]) nest_is_obj[i] = 1'b0;
    clear_scan_state();

    // directed table, array_format at its reset value
    add_row(jvds_pkg::CH_SPACE,  1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_LF,     1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_IN);
    add_row(8'hFF,               1'b0, 1'b1, 8'hFF, 1'b1, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_COMMA,  1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_COMMA);
    add_row(jvds_pkg::CH_RBRACK, 1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_CLOSE);
    add_row(jvds_pkg::CH_RBRACE, 1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_CLOSE);
    add_row(jvds_pkg::CH_NUL,    1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_BAD);
    add_row(8'hFF,               1'b1, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_BAD);
    // quoted comma, escapes inside a string
    add_row(jvds_pkg::CH_DQUOTE, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_COMMA,  1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_N,      1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_R,      1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_T,      1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_DQUOTE, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    // \u with hex digits, then \u with a non-hex lead and a NUL collected
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_U,      1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("4",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("a",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("F",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("1",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_U,      1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("g",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_NUL,    1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("2",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row("3",                 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    // unknown escape: the quote after it has no meaning
    add_row(jvds_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_SQUOTE, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_COMMA,  1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_COMMA);
    // mismatched closes
    add_row(jvds_pkg::CH_LBRACK, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_RBRACE, 1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_BAD);
    add_row(jvds_pkg::CH_LBRACE, 1'b0, 1'b0, '0, 1'b0, jvds_pkg::ST_IN);
    add_row(jvds_pkg::CH_RBRACK, 1'b0, 1'b1, 8'h00, 1'b0, jvds_pkg::ST_BAD);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].b, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].want);

    // array format: a top-level close brace is malformed
    write_format(1'b1);
    send_beat(jvds_pkg::CH_RBRACE, 1'b0, 1'b1,
              '{ob: 8'h00, ov: 1'b0, st: jvds_pkg::ST_BAD});

    // random phases over both format settings, last one with no stalls
    for (int ph = 0; ph < 6; ph++) begin
      write_format(ph[0] ? 1'b0 : 1'b1);
      if (ph == 5) gaps_on = 1'b0;
      if (ph == 2) hold_req = 1'b1;
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0: send_deep();
          1, 2: send_noise();
          default: send_value();
        endcase
      end
    end

    drain(8);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/jvds_pkg.sv
hdl/jvds_nest_stack.sv
hdl/jvds_step.sv
hdl/json_value_delimiter_scanner_core.sv
test/json_value_delimiter_scanner_core_tb.sv
